// File: src/h264_rtp_fua_packetizer_defines.svh
// Assertion macros shared by the packetizer checker.
`ifndef H264_RTP_FUA_PACKETIZER_DEFINES_SVH
`define H264_RTP_FUA_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FUA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packetizer assertion failed");

// Next-cycle implication, disabled during reset.
`define FUA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packetizer assertion failed");

`endif

// File: src/fua_pkg.sv
// Types and constants shared by the FU-A packetizer modules.
`timescale 1ns / 1ps

package fua_pkg;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_FRAGMENT_PAYLOAD = 1'b0,
      CSR_INITIAL_SEQUENCE     = 1'b1
   } csr_index_type;

   localparam logic [15:0] MAX_FRAGMENT_RESET = 16'd1400;
   localparam logic [7:0]  FU_A_TYPE          = 8'd28;
   localparam logic [7:0]  TYPE_MASK          = 8'h1F;
   localparam logic [7:0]  FNRI_MASK          = 8'hE0;
   localparam logic [7:0]  S_BIT              = 8'h80;
   localparam logic [7:0]  E_BIT              = 8'h40;

   // One classified input item: either a single byte or a fragment opener
   // that carries the two FU bytes ahead of its payload byte.
   typedef struct packed {
      logic        three;
      logic        first;
      logic        last;
      logic [15:0] seq;
      logic [7:0]  ind;
      logic [7:0]  fuh;
      logic [7:0]  data;
   } job_type;

endpackage

// File: src/fua_front.sv
// Front end: accepts NAL bytes and config writes, tracks unit/fragment state.
`timescale 1ns / 1ps

module fua_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_nal_byte,
   input  logic [19:0]                     req_nal_length,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fua_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic                            queue_full,
   output logic                            push,
   output fua_pkg::job_type                push_job
);

   logic [15:0] max_frag_ff, max_frag_in;
   logic [15:0] seq_ff, seq_in;
   logic [19:0] pos_ff, pos_in;
   logic [15:0] fill_ff, fill_in;
   logic [7:0]  held_ff, held_in;
   logic        mode_ff, mode_in;

   logic [15:0] lim;
   logic        accept;
   logic        at_start;
   logic        unit_end;
   logic        mode;
   logic        pkt_end;
   logic [19:0] rem;
   logic [7:0]  fuh;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;

   always_comb begin
      lim      = (max_frag_ff == 16'd0) ? 16'd1 : max_frag_ff;
      accept   = req_valid && !queue_full;
      at_start = (pos_ff == 20'd0);
      unit_end = (({1'b0, pos_ff} + 21'd1) >= {1'b0, req_nal_length});
      mode     = at_start ? (req_nal_length > {4'd0, lim}) : mode_ff;
      pkt_end  = unit_end || (({1'b0, fill_ff} + 17'd1) >= {1'b0, lim});
      rem      = (pos_ff < req_nal_length) ? (req_nal_length - pos_ff) : 20'd0;

      fuh = held_ff & fua_pkg::TYPE_MASK;
      if (pos_ff == 20'd1) begin
         fuh = fuh | fua_pkg::S_BIT;
      end
      if (rem <= {4'd0, lim}) begin
         fuh = fuh | fua_pkg::E_BIT;
      end

      push_job.three = mode && (fill_ff == 16'd0);
      push_job.first = !mode && at_start;
      push_job.last  = mode ? pkt_end : unit_end;
      push_job.seq   = seq_ff;
      push_job.ind   = (held_ff & fua_pkg::FNRI_MASK) | fua_pkg::FU_A_TYPE;
      push_job.fuh   = fuh;
      push_job.data  = req_nal_byte;

      // header byte of a fragmented unit is held back, nothing goes out
      push = accept && !(mode && at_start);

      max_frag_in = max_frag_ff;
      seq_in      = seq_ff;
      pos_in      = pos_ff;
      fill_in     = fill_ff;
      held_in     = held_ff;
      mode_in     = mode_ff;

      if (accept) begin
         if (!mode) begin
            if (unit_end) begin
               seq_in = seq_ff + 16'd1;
            end
         end else if (at_start) begin
            held_in = req_nal_byte;
         end else if (pkt_end) begin
            seq_in  = seq_ff + 16'd1;
            fill_in = 16'd0;
         end else begin
            fill_in = fill_ff + 16'd1;
         end

         if (unit_end) begin
            pos_in  = 20'd0;
            fill_in = 16'd0;
            mode_in = 1'b0;
         end else begin
            pos_in  = pos_ff + 20'd1;
            mode_in = mode;
         end
      end

      if (csr_valid) begin
         case (fua_pkg::csr_index_type'(csr_index))
            fua_pkg::CSR_MAX_FRAGMENT_PAYLOAD: max_frag_in = csr_wdata;
            fua_pkg::CSR_INITIAL_SEQUENCE:     seq_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frag_ff <= fua_pkg::MAX_FRAGMENT_RESET;
         seq_ff      <= 16'd0;
         pos_ff      <= 20'd0;
         fill_ff     <= 16'd0;
         held_ff     <= 8'd0;
         mode_ff     <= 1'b0;
      end else begin
         max_frag_ff <= max_frag_in;
         seq_ff      <= seq_in;
         pos_ff      <= pos_in;
         fill_ff     <= fill_in;
         held_ff     <= held_in;
         mode_ff     <= mode_in;
      end
   end

endmodule

// File: src/fua_queue.sv
// Small job queue between the front end and the emitter.
`timescale 1ns / 1ps

module fua_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fua_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output fua_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   fua_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/fua_back.sv
// Emitter: expands queued jobs into output bytes behind an output register.
`timescale 1ns / 1ps

module fua_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  fua_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_packet_first,
   output logic             rsp_packet_last,
   output logic [15:0]      rsp_sequence_number,
   output logic             rsp_run_last
);

   typedef enum logic [2:0] {
      PH_IND  = 3'b001,
      PH_FUH  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        first_ff, first_in;
   logic        last_ff, last_in;
   logic [15:0] seq_ff, seq_in;
   logic        run_last_ff, run_last_in;
   logic        load;

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_packet_first    = first_ff;
   assign rsp_packet_last     = last_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_run_last        = run_last_ff;

   always_comb begin
      load        = !valid_ff || rsp_ready;
      phase_in    = phase_ff;
      valid_in    = valid_ff && !rsp_ready;
      byte_in     = byte_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      seq_in      = seq_ff;
      run_last_in = run_last_ff;
      pop         = 1'b0;

      if (load && head_valid) begin
         valid_in = 1'b1;
         seq_in   = head_job.seq;
         if (!head_job.three) begin
            byte_in     = head_job.data;
            first_in    = head_job.first;
            last_in     = head_job.last;
            run_last_in = 1'b1;
            pop         = 1'b1;
         end else begin
            case (phase_ff)
               PH_IND: begin
                  byte_in     = head_job.ind;
                  first_in    = 1'b1;
                  last_in     = 1'b0;
                  run_last_in = 1'b0;
                  phase_in    = PH_FUH;
               end
               PH_FUH: begin
                  byte_in     = head_job.fuh;
                  first_in    = 1'b0;
                  last_in     = 1'b0;
                  run_last_in = 1'b0;
                  phase_in    = PH_DATA;
               end
               PH_DATA: begin
                  byte_in     = head_job.data;
                  first_in    = 1'b0;
                  last_in     = head_job.last;
                  run_last_in = 1'b1;
                  phase_in    = PH_IND;
                  pop         = 1'b1;
               end
               default: begin
                  valid_in = valid_ff && !rsp_ready;
                  phase_in = PH_IND;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      seq_ff      <= seq_in;
      run_last_ff <= run_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IND;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: src/h264_rtp_fua_packetizer.sv
// H.264 RTP FU-A packetizer: top level joining front end, job queue and emitter.
// Feed a NAL unit one byte per item, header byte first, with the unit's total
// length on every item. A unit no longer than max_fragment_payload (register 0,
// reset 1400, zero acts as one) comes out unchanged as one packet; a longer one
// has its header held back (that item gives no result) and the rest is cut into
// FU-A fragments, each opened by an FU indicator and FU header byte (S on the
// first fragment, E on the last). Every result byte carries the 16-bit sequence
// number of its packet; writing initial_sequence (register 1) reloads it.
// The front end classifies one item per cycle into a queue of QUEUE_DEPTH jobs;
// the emitter drains one output byte per cycle, so plain bytes flow at one item
// per cycle and an item that opens a fragment costs three output bytes, which
// backs up into req_ready only once the queue is full. Results leave from a
// register, so input keeps flowing while a result waits on rsp_ready.
// csr_ready is always high; write configuration only while the block is idle.
`timescale 1ns / 1ps

module h264_rtp_fua_packetizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_nal_byte,
   input  logic [19:0]                     req_nal_length,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_packet_first,
   output logic                            rsp_packet_last,
   output logic [15:0]                     rsp_sequence_number,
   output logic                            rsp_run_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fua_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);

   // front end -> queue
   logic             push;
   fua_pkg::job_type push_job;
   logic             queue_full;

   // queue -> emitter
   logic             head_valid;
   fua_pkg::job_type head_job;
   logic             pop;

   fua_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_nal_byte   (req_nal_byte),
      .req_nal_length (req_nal_length),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   fua_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   fua_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_job            (head_job),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_packet_first    (rsp_packet_first),
      .rsp_packet_last     (rsp_packet_last),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_run_last        (rsp_run_last)
   );

endmodule

// File: src/fua_checker.sv
// Port-level checker for the packetizer, bound to the top level.
`timescale 1ns / 1ps
`include "h264_rtp_fua_packetizer_defines.svh"

module fua_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_packet_first,
   input logic        rsp_packet_last,
   input logic        rsp_run_last
);

   localparam logic [4:0] FU_TYPE_CODE = fua_pkg::FU_A_TYPE[4:0];

   logic fu_lead;

   assign fu_lead = rsp_valid && rsp_packet_first && !rsp_run_last;

   // a stalled result stays put
   `FUA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte))

   // a packet always closes on a payload byte, the last result of its item
   `FUA_ASSERT_NOW(a_last_is_run_last, clock, reset, rsp_valid && rsp_packet_last, rsp_run_last)

   // a packet start that is not the item's last result is an FU indicator
   `FUA_ASSERT_NOW(a_fu_indicator, clock, reset, fu_lead, rsp_out_byte[4:0] == FU_TYPE_CODE)

   // FU bytes are followed without a gap by the rest of their item
   `FUA_ASSERT_NEXT(a_fu_burst, clock, reset, rsp_valid && rsp_ready && !rsp_run_last, rsp_valid)

endmodule

bind h264_rtp_fua_packetizer fua_checker u_fua_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_packet_first (rsp_packet_first),
   .rsp_packet_last  (rsp_packet_last),
   .rsp_run_last     (rsp_run_last)
);
